### rtl/core/spm_pkg.sv
// spm_pkg: shared constants, register codes and types of the substring pattern matcher
// used by spm_cell, spm_result_fifo and substring_pattern_matcher_core; no dependencies
package spm_pkg;

    localparam int PAT_MAX_DEF  = 32;
    localparam int TEXT_MAX_DEF = 1024;

    localparam int BYTE_W      = 8;
    localparam int PAT_REGS    = 4;
    localparam int PAT_REG_W   = 64;
    localparam int PAT_IDX_W   = 5;
    localparam int LEN_W       = 6;
    localparam int POS_W       = 11;
    localparam int CFG_IDX_W   = 3;
    localparam int M_TDATA_W   = 16;
    localparam int FIFO_DEPTH  = 4;
    localparam int FIFO_PTR_W  = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PAT_0_7   = 3'd0,
        CFG_PAT_8_15  = 3'd1,
        CFG_PAT_16_23 = 3'd2,
        CFG_PAT_24_31 = 3'd3,
        CFG_PAT_LEN   = 3'd4
    } cfg_reg_t;

    typedef struct packed {
        logic win_shift;
        logic pat_shift;
    } spm_cell_ctrl_t;

    typedef struct packed {
        logic             length_overflow;
        logic [POS_W-1:0] match_position;
        logic             match_found;
    } spm_result_t;

    localparam int RES_W = $bits(spm_result_t);

endpackage

### rtl/core/spm_cell.sv
// spm_cell: one cell of the matcher chain, holds a text byte and its aligned pattern byte
// depends on spm_pkg
module spm_cell
    import spm_pkg::*;
(
    input  logic                aclk,
    input  spm_cell_ctrl_t      ctrl,
    input  logic [BYTE_W-1:0]   win_in,
    input  logic [BYTE_W-1:0]   pat_in,
    input  logic                active,
    output logic [BYTE_W-1:0]   win_out,
    output logic [BYTE_W-1:0]   pat_out,
    output logic                hit
);

    logic [BYTE_W-1:0] win_reg, win_next;
    logic [BYTE_W-1:0] pat_reg, pat_next;

    always_comb begin
        win_next = ctrl.win_shift ? win_in : win_reg;
        pat_next = ctrl.pat_shift ? pat_in : pat_reg;
    end

    always_ff @(posedge aclk) begin
        win_reg <= win_next;
        pat_reg <= pat_next;
    end

    assign win_out = win_reg;
    assign pat_out = pat_reg;
    // cells beyond the pattern length always agree
    assign hit     = !active || (win_reg == pat_reg);

endmodule

### rtl/core/spm_result_fifo.sv
// spm_result_fifo: small result queue in front of the master side
// depends on spm_pkg
module spm_result_fifo
    import spm_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  push,
    input  spm_result_t           push_data,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,
    output logic [FIFO_PTR_W:0]   count
);

    spm_result_t             entry_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [FIFO_PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [FIFO_PTR_W:0]     cnt_reg, cnt_next;
    logic                    pop;

    assign m_tvalid = (cnt_reg != '0);
    assign pop      = m_tvalid && m_tready;
    assign m_tdata  = {{(M_TDATA_W-RES_W){1'b0}}, entry_reg[rd_ptr_reg]};
    assign count    = cnt_reg;

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push && !pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (pop && !push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

### rtl/core/substring_pattern_matcher_core.sv
// substring_pattern_matcher_core: top level, chain of compare cells, search state and
// configuration; depends on spm_pkg, spm_cell and spm_result_fifo
//
//   channel  direction  handshake           payload
//   s_       in         s_tvalid/s_tready   tdata text_byte, tuser first_byte, tlast last_byte
//   m_       out        m_tvalid/m_tready   tdata match_found, match_position, length_overflow
//   cfg_     in         cfg_valid/cfg_ready cfg_index register, cfg_data value
//
// one text byte per cycle while s_tready is high; a result passes shift, then compare
// after reset and after every register write the pattern is shifted into the cells
// with s_tready low meanwhile
// a four-entry result queue keeps s_tready up while results wait; outside a pattern load it
// drops only when the queue cannot take one more result
// aresetn is synchronous, active low
module substring_pattern_matcher_core
    import spm_pkg::*;
#(
    parameter int PAT_MAX  = PAT_MAX_DEF,
    parameter int TEXT_MAX = TEXT_MAX_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [BYTE_W-1:0]     s_tdata,   // [7:0] text_byte
    input  logic                  s_tuser,   // [0] first_byte
    input  logic                  s_tlast,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,   // [0] match_found, [11:1] match_position,
                                             // [12] length_overflow, [15:13] zero
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [PAT_REG_W-1:0]  cfg_data
);

    localparam int CNT_W = $clog2(TEXT_MAX + 1);

    // configuration
    logic [PAT_REG_W-1:0]           pat_reg [PAT_REGS];
    logic [PAT_REG_W-1:0]           pat_next [PAT_REGS];
    logic [LEN_W-1:0]               len_reg, len_next;
    logic [PAT_REGS*PAT_REG_W-1:0]  pat_flat;
    logic [LEN_W-1:0]               len_c;
    logic                           cfg_acc;

    // pattern load sweep
    logic                           load_busy_reg, load_busy_next;
    logic [LEN_W-1:0]               load_idx_reg, load_idx_next;
    logic                           load_step;
    logic [BYTE_W-1:0]              load_byte;

    // shift stage
    logic                           s_acc;
    logic [CNT_W-1:0]               byte_count_reg, byte_count_next;
    logic [CNT_W-1:0]               cnt_a, cnt_inc;
    logic                           sat;

    // compare stage
    logic                           b_valid_reg;
    logic                           b_first_reg, b_last_reg, b_search_reg;
    logic [CNT_W-1:0]               b_count_reg;
    logic                           found_reg, found_next;
    logic [CNT_W-1:0]               pos_reg, pos_next;
    logic                           ovf_reg, ovf_next;
    logic                           found_base, ovf_base;
    logic [CNT_W-1:0]               pos_base, pos_calc, len_ext;
    logic                           found_new, ovf_new, hit_now;
    logic [CNT_W-1:0]               pos_new;
    logic [CNT_W+POS_W-1:0]         pos_wide;

    // cell chain
    spm_cell_ctrl_t                 cell_ctrl;
    logic [BYTE_W-1:0]              win_out [PAT_MAX];
    logic [BYTE_W-1:0]              pat_out [PAT_MAX];
    logic [PAT_MAX-1:0]             hit;
    logic                           all_hit;

    // result queue
    logic                           push;
    spm_result_t                    push_data;
    logic [FIFO_PTR_W:0]            fifo_cnt;
    logic [FIFO_PTR_W+1:0]          fifo_need;

    assign cfg_ready = 1'b1;
    assign cfg_acc   = cfg_valid && cfg_ready;

    genvar r;
    generate
        for (r = 0; r < PAT_REGS; r++) begin : g_flat
            assign pat_flat[r*PAT_REG_W +: PAT_REG_W] = pat_reg[r];
        end
    endgenerate

    assign len_c = (len_reg > LEN_W'(PAT_MAX)) ? LEN_W'(PAT_MAX) : len_reg;

    always_comb begin
        for (int i = 0; i < PAT_REGS; i++) begin
            pat_next[i] = pat_reg[i];
        end
        len_next = len_reg;
        if (cfg_acc) begin
            case (cfg_reg_t'(cfg_index))
                CFG_PAT_0_7:   pat_next[0] = cfg_data;
                CFG_PAT_8_15:  pat_next[1] = cfg_data;
                CFG_PAT_16_23: pat_next[2] = cfg_data;
                CFG_PAT_24_31: pat_next[3] = cfg_data;
                CFG_PAT_LEN:   len_next    = cfg_data[LEN_W-1:0];
                default:       len_next    = len_reg;
            endcase
        end
    end

    // pattern bytes go in oldest first, so cell k ends up with byte len-1-k
    assign load_step = load_busy_reg && (load_idx_reg != len_c);
    assign load_byte = pat_flat[{load_idx_reg[PAT_IDX_W-1:0], 3'b000} +: BYTE_W];

    always_comb begin
        load_busy_next = load_busy_reg;
        load_idx_next  = load_idx_reg;
        if (cfg_acc) begin
            load_busy_next = 1'b1;
            load_idx_next  = '0;
        end else if (load_busy_reg) begin
            if (load_step) begin
                load_idx_next = load_idx_reg + 1'b1;
            end else begin
                load_busy_next = 1'b0;
            end
        end
    end

    // accept only outside a pattern load and while the queue still has room for this result
    assign push      = b_valid_reg && b_last_reg;
    assign fifo_need = {1'b0, fifo_cnt} + (FIFO_PTR_W+2)'(push);
    assign s_tready  = !load_busy_reg && (fifo_need < (FIFO_PTR_W+2)'(FIFO_DEPTH));
    assign s_acc     = s_tvalid && s_tready;

    assign cnt_a   = s_tuser ? '0 : byte_count_reg;
    assign sat     = (cnt_a >= CNT_W'(TEXT_MAX));
    assign cnt_inc = cnt_a + 1'b1;

    always_comb begin
        byte_count_next = byte_count_reg;
        if (s_acc) begin
            if (s_tlast) begin
                byte_count_next = '0;
            end else if (!sat) begin
                byte_count_next = cnt_inc;
            end else begin
                byte_count_next = cnt_a;
            end
        end
    end

    assign cell_ctrl.win_shift = s_acc && !sat;
    assign cell_ctrl.pat_shift = load_step;

    genvar k;
    generate
        for (k = 0; k < PAT_MAX; k++) begin : g_cell
            logic [BYTE_W-1:0] win_in;
            logic [BYTE_W-1:0] pat_in;
            if (k == 0) begin : g_head
                assign win_in = s_tdata;
                assign pat_in = load_byte;
            end else begin : g_link
                assign win_in = win_out[k-1];
                assign pat_in = pat_out[k-1];
            end
            spm_cell u_cell (
                .aclk    (aclk),
                .ctrl    (cell_ctrl),
                .win_in  (win_in),
                .pat_in  (pat_in),
                .active  (LEN_W'(k) < len_c),
                .win_out (win_out[k]),
                .pat_out (pat_out[k]),
                .hit     (hit[k])
            );
        end
    endgenerate

    assign all_hit = &hit;

    // compare stage, window already holds the item's byte
    assign len_ext    = {{(CNT_W-LEN_W){1'b0}}, len_c};
    assign found_base = b_first_reg ? 1'b0 : found_reg;
    assign pos_base   = b_first_reg ? '0 : pos_reg;
    assign ovf_base   = b_first_reg ? 1'b0 : ovf_reg;
    assign hit_now    = b_search_reg && all_hit && (b_count_reg >= len_ext);
    assign pos_calc   = (len_c == '0) ? CNT_W'(1) : (b_count_reg - len_ext + 1'b1);
    assign found_new  = found_base || hit_now;
    assign pos_new    = found_base ? pos_base : (hit_now ? pos_calc : '0);
    assign ovf_new    = ovf_base || !b_search_reg;
    assign pos_wide   = {{POS_W{1'b0}}, pos_new};

    assign push_data.match_found     = found_new;
    assign push_data.match_position  = pos_wide[POS_W-1:0];
    assign push_data.length_overflow = ovf_new;

    always_comb begin
        found_next = found_reg;
        pos_next   = pos_reg;
        ovf_next   = ovf_reg;
        if (b_valid_reg) begin
            if (b_last_reg) begin
                found_next = 1'b0;
                pos_next   = '0;
                ovf_next   = 1'b0;
            end else begin
                found_next = found_new;
                pos_next   = pos_new;
                ovf_next   = ovf_new;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_acc) begin
            b_first_reg  <= s_tuser;
            b_last_reg   <= s_tlast;
            b_search_reg <= !sat;
            b_count_reg  <= cnt_inc;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < PAT_REGS; i++) begin
                pat_reg[i] <= '0;
            end
            len_reg        <= '0;
            load_busy_reg  <= 1'b1;
            load_idx_reg   <= '0;
            byte_count_reg <= '0;
            b_valid_reg    <= 1'b0;
            found_reg      <= 1'b0;
            pos_reg        <= '0;
            ovf_reg        <= 1'b0;
        end else begin
            for (int i = 0; i < PAT_REGS; i++) begin
                pat_reg[i] <= pat_next[i];
            end
            len_reg        <= len_next;
            load_busy_reg  <= load_busy_next;
            load_idx_reg   <= load_idx_next;
            byte_count_reg <= byte_count_next;
            b_valid_reg    <= s_acc;
            found_reg      <= found_next;
            pos_reg        <= pos_next;
            ovf_reg        <= ovf_next;
        end
    end

    spm_result_fifo u_result_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .count     (fifo_cnt)
    );

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        byte_count_reg <= CNT_W'(TEXT_MAX))
        else $error("byte count beyond text limit");

    a_found_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        found_reg == (pos_reg != '0))
        else $error("found flag and match position disagree");

    a_queue_room: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> (fifo_cnt < (FIFO_PTR_W+1)'(FIFO_DEPTH)) || m_tready)
        else $error("result pushed into a full queue");

    a_no_accept_loading: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_acc |=> !s_tready)
        else $error("input taken before pattern load");
`endif

endmodule

### sim/substring_pattern_matcher_core_test.sv
`timescale 1ns / 1ps
// substring_pattern_matcher_core_test: self-checking bench for the substring pattern matcher;
// a tracker class predicts every search report from the accepted bytes and register writes
// depends on spm_pkg and substring_pattern_matcher_core
module substring_pattern_matcher_core_test;
    import spm_pkg::*;

    class text_search_tracker;
        logic [PAT_REG_W-1:0] pattern_words[PAT_REGS];
        logic [LEN_W-1:0]     pattern_len;
        logic [BYTE_W-1:0]    recent[PAT_MAX_DEF];
        int unsigned          byte_count;
        logic                 found;
        logic [POS_W-1:0]     first_pos;
        logic                 overflow;
        spm_result_t          expected_reports[$];
        int unsigned          mismatches;

        function new();
            foreach (pattern_words[i]) pattern_words[i] = '0;
            pattern_len = '0;
            mismatches  = 0;
            clear_search();
        endfunction

        function void clear_search();
            foreach (recent[i]) recent[i] = '0;
            byte_count = 0;
            found      = 1'b0;
            first_pos  = '0;
            overflow   = 1'b0;
        endfunction

        function int unsigned active_len();
            return (pattern_len > PAT_MAX_DEF) ? PAT_MAX_DEF : int'(pattern_len);
        endfunction

        function logic [BYTE_W-1:0] pattern_byte(int unsigned i);
            return pattern_words[i / 8][(i % 8) * 8 +: 8];
        endfunction

        function void write_register(cfg_reg_t idx, logic [PAT_REG_W-1:0] value);
            if (idx == CFG_PAT_LEN) begin
                pattern_len = value[LEN_W-1:0];
            end else begin
                pattern_words[int'(idx)] = value;
            end
        endfunction

        function void accept_byte(logic [BYTE_W-1:0] b, logic first, logic last);
            int unsigned len;
            int          k;
            bit          hit;
            spm_result_t report;
            len = active_len();
            if (first) clear_search();
            if (byte_count >= TEXT_MAX_DEF) begin
                overflow = 1'b1;
            end else begin
                for (k = PAT_MAX_DEF - 1; k > 0; k--) recent[k] = recent[k - 1];
                recent[0] = b;
                byte_count++;
                if (!found) begin
                    if (len == 0) begin
                        found     = 1'b1;
                        first_pos = 1;
                    end else if (byte_count >= len) begin
                        hit = 1'b1;
                        for (k = 0; k < len; k++) begin
                            if (recent[k] != pattern_byte(len - 1 - k)) hit = 1'b0;
                        end
                        if (hit) begin
                            found     = 1'b1;
                            first_pos = POS_W'(byte_count - len + 1);
                        end
                    end
                end
            end
            if (last) begin
                report.match_found     = found;
                report.match_position  = first_pos;
                report.length_overflow = overflow;
                expected_reports.push_back(report);
                clear_search();
            end
        endfunction

        function void check_report(logic [M_TDATA_W-1:0] tdata);
            spm_result_t want;
            spm_result_t got;
            if (expected_reports.size() == 0) begin
                $display("%0t: result transfer with none expected, tdata %h", $time, tdata);
                mismatches++;
                return;
            end
            want = expected_reports.pop_front();
            got  = spm_result_t'(tdata[RES_W-1:0]);
            if (got.match_found !== want.match_found) begin
                $display("%0t: match_found expected %0d actual %0d",
                         $time, want.match_found, got.match_found);
                mismatches++;
            end
            if (got.match_position !== want.match_position) begin
                $display("%0t: match_position expected %0d actual %0d",
                         $time, want.match_position, got.match_position);
                mismatches++;
            end
            if (got.length_overflow !== want.length_overflow) begin
                $display("%0t: length_overflow expected %0d actual %0d",
                         $time, want.length_overflow, got.length_overflow);
                mismatches++;
            end
            if (tdata[M_TDATA_W-1:RES_W] !== '0) begin
                $display("%0t: tdata padding expected 0 actual %h",
                         $time, tdata[M_TDATA_W-1:RES_W]);
                mismatches++;
            end
        endfunction
    endclass

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [BYTE_W-1:0]    s_tdata   = '0;
    logic                 s_tuser   = 1'b0;
    logic                 s_tlast   = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [PAT_REG_W-1:0] cfg_data  = '0;

    text_search_tracker   tracker;
    logic [BYTE_W-1:0]    text_buf[$];
    logic [PAT_REG_W-1:0] pattern_plan[PAT_REGS];
    logic [PAT_REG_W-1:0] len_plan;
    int                   idle_pct     = 11;
    bit                   hold_request = 1'b0;
    int                   hold_left    = 0;
    int unsigned          sent_count   = 0;

    substring_pattern_matcher_core u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // result side: checks each transfer, stalls at random or for a requested hold-off
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) tracker.check_report(m_tdata);
        if (hold_request) begin
            hold_left    = 300;
            hold_request = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= idle_pct);
        end
    end

    task automatic send_byte(logic [BYTE_W-1:0] b, logic first, logic last);
        if ($urandom_range(99) < idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tuser  <= first;
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
        tracker.accept_byte(b, first, last);
        sent_count++;
    endtask

    // broken texts may lose the start mark or carry stray start and last marks
    task automatic send_text(bit broken);
        int  i;
        logic first;
        logic last;
        for (i = 0; i < text_buf.size(); i++) begin
            first = (i == 0);
            last  = (i == text_buf.size() - 1);
            if (broken) begin
                first = (i == 0) ? 1'($urandom_range(1)) : ($urandom_range(15) == 0);
                last  = last || ($urandom_range(15) == 0);
            end
            send_byte(text_buf[i], first, last);
        end
    endtask

    function automatic logic [PAT_REG_W-1:0] narrow_word();
        logic [PAT_REG_W-1:0] w;
        int i;
        for (i = 0; i < 8; i++) w[i * 8 +: 8] = 8'h61 + 8'($urandom_range(1));
        return w;
    endfunction

    function automatic void build_text(int unsigned tlen, bit narrow, bit plant);
        int unsigned plen;
        int unsigned start;
        int unsigned i;
        text_buf.delete();
        for (i = 0; i < tlen; i++) begin
            text_buf.push_back(narrow ? 8'h61 + 8'($urandom_range(1)) : 8'($urandom));
        end
        plen = tracker.active_len();
        if (plant && plen > 0 && plen <= tlen) begin
            start = $urandom_range(tlen - plen);
            for (i = 0; i < plen; i++) text_buf[start + i] = tracker.pattern_byte(i);
        end
    endfunction

    task automatic write_reg(cfg_reg_t idx, logic [PAT_REG_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        tracker.write_register(idx, value);
    endtask

    task automatic load_pattern();
        int i;
        for (i = 0; i < PAT_REGS; i++) write_reg(cfg_reg_t'(i), pattern_plan[i]);
        write_reg(CFG_PAT_LEN, len_plan);
        cfg_valid <= 1'b0;
    endtask

    function automatic void plan_pattern(bit narrow);
        int i;
        int unsigned len;
        for (i = 0; i < PAT_REGS; i++) begin
            pattern_plan[i] = narrow ? narrow_word() : {$urandom, $urandom};
        end
        case ($urandom_range(9))
            0:       len = 0;
            1:       len = $urandom_range(33, 63);
            2:       len = PAT_MAX_DEF;
            default: len = $urandom_range(1, 12);
        endcase
        len_plan = {$urandom, $urandom};
        len_plan[LEN_W-1:0] = LEN_W'(len);
    endfunction

    // lower the input, wait for every outstanding result, let the pipeline empty
    task automatic quiesce();
        s_tvalid <= 1'b0;
        while (tracker.expected_reports.size() != 0) @(posedge aclk);
        repeat (6) @(posedge aclk);
    endtask

    initial begin
        #5_000_000;
        $display("substring_pattern_matcher_core_test: errors");
        $finish;
    end

    initial begin
        int          phase;
        int          t;
        int          n;
        bit          narrow;
        int unsigned base;
        int unsigned tlen;

        tracker = new();
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // two byte pattern ff 00
        pattern_plan[0] = 64'h0000_0000_0000_00FF;
        pattern_plan[1] = 64'h0;
        pattern_plan[2] = 64'h0;
        pattern_plan[3] = 64'hFFFF_FFFF_FFFF_FFFF;
        len_plan        = 64'd2;
        load_pattern();
        send_byte(8'hFF, 1'b1, 1'b0);
        send_byte(8'h00, 1'b0, 1'b1);
        // text shorter than the pattern
        send_byte(8'h00, 1'b1, 1'b1);
        send_byte(8'h37, 1'b1, 1'b0);
        send_byte(8'hFF, 1'b0, 1'b0);
        send_byte(8'h00, 1'b0, 1'b1);
        // no start mark
        send_byte(8'h12, 1'b0, 1'b0);
        send_byte(8'hFF, 1'b0, 1'b0);
        send_byte(8'h00, 1'b0, 1'b1);
        // start mark again in the middle of a text
        send_byte(8'hFF, 1'b1, 1'b0);
        send_byte(8'hFF, 1'b1, 1'b0);
        send_byte(8'h00, 1'b0, 1'b1);

        // empty pattern
        quiesce();
        len_plan = 64'd0;
        load_pattern();
        send_byte(8'h80, 1'b1, 1'b1);
        send_byte(8'h01, 1'b1, 1'b0);
        send_byte(8'h7F, 1'b0, 1'b1);

        // length above the maximum, clamped
        quiesce();
        pattern_plan[0] = 64'hAAAA_5555_0F0F_F0F0;
        pattern_plan[1] = 64'h1234_5678_9ABC_DEF0;
        pattern_plan[2] = 64'hFFFF_FFFF_FFFF_FFFF;
        len_plan        = 64'hFFFF_FFFF_FFFF_FFFF;
        load_pattern();
        send_byte(8'hF0, 1'b1, 1'b0);
        send_byte(8'h0F, 1'b0, 1'b0);
        send_byte(8'h55, 1'b0, 1'b1);

        // one zero byte pattern against the cleared window
        quiesce();
        pattern_plan[0] = 64'hFFFF_FFFF_FFFF_FF00;
        len_plan        = 64'd1;
        load_pattern();
        send_byte(8'hFF, 1'b1, 1'b1);
        send_byte(8'h10, 1'b1, 1'b0);
        send_byte(8'h20, 1'b0, 1'b0);
        send_byte(8'h00, 1'b0, 1'b1);

        base  = sent_count;
        phase = 0;
        while (sent_count < base + 1500) begin
            narrow = $urandom_range(1);
            plan_pattern(narrow);
            quiesce();
            idle_pct = (phase == 1) ? 0 : 11;
            load_pattern();

            if (phase == 0) begin
                // receiver holds off while short texts keep coming
                hold_request = 1'b1;
                for (t = 0; t < 40; t++) send_byte(8'($urandom), 1'b1, 1'b1);
                quiesce();
            end

            if (phase == 1) begin
                // text beyond the length limit, no idling on either side
                tlen = TEXT_MAX_DEF + $urandom_range(1, 8);
                build_text(tlen, 1'b0, 1'b1);
                send_text(1'b0);
            end

            n = $urandom_range(4, 10);
            for (t = 0; t < n; t++) begin
                tlen = ($urandom_range(3) == 0) ? $urandom_range(1, 3) : $urandom_range(1, 40);
                build_text(tlen, narrow, 1'($urandom_range(1)));
                send_text($urandom_range(9) == 0);
                if ($urandom_range(19) == 0) quiesce();
            end
            // always close the phase on a last byte
            send_byte(8'($urandom), 1'($urandom_range(1)), 1'b1);
            phase++;
        end

        quiesce();
        repeat (20) @(posedge aclk);
        if (tracker.mismatches == 0) begin
            $display("substring_pattern_matcher_core_test: clean");
        end else begin
            $display("substring_pattern_matcher_core_test: errors");
        end
        $finish;
    end

endmodule
